>>> hw/rtl/rosi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosi_pkg: shared types and constants of the retry outbox core
// Transaction structs, configuration indexes and reset values, opcodes,
// event kinds and the outbox entry layout.
// ----------------------------------------------------------------------------
package rosi_pkg;

  // Default outbox ring depth
  localparam int unsigned OutboxDepth = 16;

  // Most results one input transaction can produce (lost, drop, queue, sent, answered)
  localparam int unsigned MaxEvents = 5;
  localparam int unsigned EvCntW    = 3;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgIdxQueuedMode = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxCapacity   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxInterval   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxTimeout    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxRetryLimit = 3'd4;

  localparam logic        RstQueuedMode = 1'b1;
  localparam logic [4:0]  RstCapacity   = 5'd16;
  localparam logic [15:0] RstInterval   = 16'd1000;
  localparam logic [15:0] RstTimeout    = 16'd3000;
  localparam logic [3:0]  RstRetryLimit = 4'd2;

  // Opcodes
  localparam logic [1:0] OpRead   = 2'd0;
  localparam logic [1:0] OpPoll   = 2'd1;
  localparam logic [1:0] OpAnswer = 2'd2;

  // Event kinds
  localparam logic [2:0] EvSent        = 3'd0;
  localparam logic [2:0] EvQueued      = 3'd1;
  localparam logic [2:0] EvDropOldest  = 3'd2;
  localparam logic [2:0] EvDropNoStore = 3'd3;
  localparam logic [2:0] EvSendFail    = 3'd4;
  localparam logic [2:0] EvLost        = 3'd5;
  localparam logic [2:0] EvAbandoned   = 3'd6;
  localparam logic [2:0] EvAnswered    = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [31:0] tag_id;
    logic        link_ready;
    logic        send_ok;
    logic [9:0]  sync_status;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] read_tag;
    logic [4:0]  attempt_count;
    logic [31:0] latency_ms;
    logic [4:0]  pending_count;
    logic [9:0]  answer_status;
    logic        last_event;
  } out_item_t;

  typedef struct packed {
    logic        queued_answer_mode;
    logic [4:0]  outbox_capacity;
    logic [15:0] retry_interval_ms;
    logic [15:0] response_timeout_ms;
    logic [3:0]  retry_limit;
  } cfg_t;

  // One outbox slot
  typedef struct packed {
    logic [31:0] tag;
    logic [4:0]  att;
  } entry_t;

  // Results of one transaction handed to the event buffer
  typedef struct packed {
    logic                          load;
    logic [EvCntW-1:0]             n;
    out_item_t [MaxEvents-1:0]     ev;
  } ev_batch_t;

  // Attempt counter, saturating at 31
  function automatic logic [4:0] sat_inc(input logic [4:0] a);
    return (a == 5'd31) ? a : a + 5'd1;
  endfunction

endpackage

>>> hw/rtl/rosi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosi_ram: generic RAM, one write port, two registered read ports
// A read at the address being written returns the new data.
// ----------------------------------------------------------------------------
module rosi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // Write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads with write-through
  always_ff @(posedge clk_i) begin
    rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
    rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hw/rtl/rosi_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosi_cfg: configuration registers
// Plain indexed write port; registers come out of reset at their defaults.
// ----------------------------------------------------------------------------
module rosi_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rosi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rosi_pkg::CfgDataW-1:0]  cfg_data_i,
  output rosi_pkg::cfg_t                 cfg_o
);

  rosi_pkg::cfg_t cfg_q;
  rosi_pkg::cfg_t cfg_d;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rosi_pkg::CfgIdxQueuedMode: cfg_d.queued_answer_mode  = cfg_data_i[0];
        rosi_pkg::CfgIdxCapacity:   cfg_d.outbox_capacity     = cfg_data_i[4:0];
        rosi_pkg::CfgIdxInterval:   cfg_d.retry_interval_ms   = cfg_data_i;
        rosi_pkg::CfgIdxTimeout:    cfg_d.response_timeout_ms = cfg_data_i;
        rosi_pkg::CfgIdxRetryLimit: cfg_d.retry_limit         = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.queued_answer_mode  <= rosi_pkg::RstQueuedMode;
      cfg_q.outbox_capacity     <= rosi_pkg::RstCapacity;
      cfg_q.retry_interval_ms   <= rosi_pkg::RstInterval;
      cfg_q.response_timeout_ms <= rosi_pkg::RstTimeout;
      cfg_q.retry_limit         <= rosi_pkg::RstRetryLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/rosi_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosi_engine: input register, sender state and single-pass event logic
// Works out every event of one transaction and the next sender state
// combinationally, hands the event list to the event buffer and updates the outbox RAM.
// ----------------------------------------------------------------------------
module rosi_engine #(
  parameter int unsigned OUTBOX_DEPTH = rosi_pkg::OutboxDepth,
  localparam int unsigned IdxW = (OUTBOX_DEPTH > 1) ? $clog2(OUTBOX_DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rosi_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rosi_pkg::in_item_t   in_item_i,
  input  logic                 buf_free_i,
  output rosi_pkg::ev_batch_t  batch_o,
  output logic                 ram_we_o,
  output logic [IdxW-1:0]      ram_waddr_o,
  output rosi_pkg::entry_t     ram_wdata_o,
  output logic [IdxW-1:0]      ram_raddr_a_o,
  output logic [IdxW-1:0]      ram_raddr_b_o,
  input  rosi_pkg::entry_t     ram_rdata_a_i,
  input  rosi_pkg::entry_t     ram_rdata_b_i
);

  localparam logic [8:0]      DepthV  = 9'(OUTBOX_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(OUTBOX_DEPTH - 1);
  localparam int unsigned     EvCntW  = rosi_pkg::EvCntW;
  localparam int unsigned     MaxEv   = rosi_pkg::MaxEvents;

  // Ring helpers
  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] h);
    return (h == LastIdx) ? '0 : IdxW'(h + 1'b1);
  endfunction

  function automatic logic [IdxW-1:0] ring_add(input logic [IdxW-1:0] h, input logic [4:0] c);
    logic [8:0] s;
    s = 9'(h) + 9'(c);
    if (s >= DepthV) begin
      s = s - DepthV;
    end
    return s[IdxW-1:0];
  endfunction

  function automatic rosi_pkg::out_item_t mk_ev(
    input logic [2:0]  kind,
    input logic [31:0] tag,
    input logic [4:0]  att,
    input logic [31:0] lat,
    input logic [4:0]  pend,
    input logic [9:0]  status
  );
    rosi_pkg::out_item_t e;
    e.event_kind    = kind;
    e.read_tag      = tag;
    e.attempt_count = att;
    e.latency_ms    = lat;
    e.pending_count = pend;
    e.answer_status = status;
    e.last_event    = 1'b0;
    return e;
  endfunction

  // Input register
  logic               in_valid_q;
  rosi_pkg::in_item_t in_q;
  logic               fire;
  logic               in_acc;

  // Sender state
  logic [IdxW-1:0] head_q, head_d;
  logic [4:0]      count_q, count_d;
  logic            busy_q, busy_d;
  logic [31:0]     slot_tag_q, slot_tag_d;
  logic [4:0]      slot_att_q, slot_att_d;
  logic [31:0]     slot_sent_q, slot_sent_d;
  logic [31:0]     flush_at_q, flush_at_d;

  // Working signals of the single pass
  rosi_pkg::out_item_t [MaxEv-1:0] evs;
  logic [EvCntW-1:0] ev_n;
  logic              enq_req;
  logic [31:0]       enq_tag;
  logic [4:0]        enq_att;
  logic              dropped;
  logic              wr_en;
  logic [IdxW-1:0]   wr_pos;
  rosi_pkg::entry_t  fl_entry;
  logic [4:0]        fl_att;
  logic [4:0]        cap;
  logic [31:0]       age;
  logic [31:0]       flush_gap;

  assign fire       = in_valid_q && buf_free_i;
  assign in_stall_o = in_valid_q && !fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Capacity clipped to the ring depth
  assign cap = ({4'b0, cfg_i.outbox_capacity} > DepthV) ? DepthV[4:0]
                                                        : cfg_i.outbox_capacity;

  assign age       = in_q.now_ms - slot_sent_q;
  assign flush_gap = in_q.now_ms - flush_at_q;

  // Hold the transaction until the event buffer can take its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_item_i;
    end
  end

  // Event list and next state: send, expire or answer, then enqueue, then flush
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    busy_d      = busy_q;
    slot_tag_d  = slot_tag_q;
    slot_att_d  = slot_att_q;
    slot_sent_d = slot_sent_q;
    flush_at_d  = flush_at_q;
    evs         = '0;
    ev_n        = '0;
    enq_req     = 1'b0;
    enq_tag     = in_q.tag_id;
    enq_att     = '0;
    dropped     = 1'b0;
    wr_en       = 1'b0;
    wr_pos      = head_q;
    fl_entry    = ram_rdata_a_i;
    fl_att      = '0;

    if (fire) begin
      unique case (in_q.opcode)
        rosi_pkg::OpRead: begin
          if (in_q.link_ready && !(cfg_i.queued_answer_mode && busy_q)) begin
            slot_tag_d  = in_q.tag_id;
            slot_att_d  = 5'd1;
            slot_sent_d = in_q.now_ms;
            if (!in_q.send_ok) begin
              busy_d = 1'b0;
              evs[ev_n] = mk_ev(rosi_pkg::EvSendFail, in_q.tag_id, 5'd1, '0, count_d, '0);
              ev_n = ev_n + 1'b1;
              enq_req = 1'b1;
            end else begin
              busy_d = 1'b1;
              evs[ev_n] = mk_ev(rosi_pkg::EvSent, in_q.tag_id, 5'd1, '0, count_d, '0);
              ev_n = ev_n + 1'b1;
              if (in_q.sync_status != '0) begin
                busy_d = 1'b0;
                evs[ev_n] = mk_ev(rosi_pkg::EvAnswered, in_q.tag_id, 5'd1, '0, count_d,
                                  in_q.sync_status);
                ev_n = ev_n + 1'b1;
              end
            end
          end else begin
            enq_req = 1'b1;
          end
        end
        rosi_pkg::OpPoll: begin
          // Expire an unanswered read
          if (busy_q && (age >= {16'b0, cfg_i.response_timeout_ms})) begin
            busy_d = 1'b0;
            evs[ev_n] = mk_ev(rosi_pkg::EvLost, slot_tag_q, slot_att_q, '0, count_d, '0);
            ev_n = ev_n + 1'b1;
            if (slot_att_q <= {1'b0, cfg_i.retry_limit}) begin
              enq_req = 1'b1;
              enq_tag = slot_tag_q;
              enq_att = slot_att_q;
            end else begin
              evs[ev_n] = mk_ev(rosi_pkg::EvAbandoned, slot_tag_q, slot_att_q, '0, count_d,
                                '0);
              ev_n = ev_n + 1'b1;
            end
          end
        end
        rosi_pkg::OpAnswer: begin
          if (busy_q) begin
            busy_d = 1'b0;
            evs[ev_n] = mk_ev(rosi_pkg::EvAnswered, slot_tag_q, slot_att_q, age, count_d,
                              in_q.sync_status);
          end else begin
            evs[ev_n] = mk_ev(rosi_pkg::EvAnswered, '0, '0, '0, count_d, in_q.sync_status);
          end
          ev_n = ev_n + 1'b1;
        end
        default: ;
      endcase

      // Enqueue, dropping the oldest entry when full, or the new one when capacity is zero
      if (enq_req) begin
        if (cap == '0) begin
          evs[ev_n] = mk_ev(rosi_pkg::EvDropNoStore, enq_tag, enq_att, '0, count_d, '0);
          ev_n = ev_n + 1'b1;
        end else begin
          if (count_d >= cap) begin
            dropped = 1'b1;
            head_d  = ring_next(head_d);
            count_d = count_d - 1'b1;
            evs[ev_n] = mk_ev(rosi_pkg::EvDropOldest, ram_rdata_a_i.tag, ram_rdata_a_i.att,
                              '0, count_d, '0);
            ev_n = ev_n + 1'b1;
          end
          wr_en   = 1'b1;
          wr_pos  = ring_add(head_d, count_d);
          count_d = count_d + 1'b1;
          evs[ev_n] = mk_ev(rosi_pkg::EvQueued, enq_tag, enq_att, '0, count_d, '0);
          ev_n = ev_n + 1'b1;
        end
      end

      // Flush the outbox head, paced by the retry interval
      if ((in_q.opcode == rosi_pkg::OpPoll) && (count_d != '0) && in_q.link_ready &&
          !(cfg_i.queued_answer_mode && busy_d) && !flush_gap[31]) begin
        if (wr_en && (wr_pos == head_d)) begin
          fl_entry.tag = enq_tag;
          fl_entry.att = enq_att;
        end else if (dropped) begin
          fl_entry = ram_rdata_b_i;
        end else begin
          fl_entry = ram_rdata_a_i;
        end
        fl_att      = rosi_pkg::sat_inc(fl_entry.att);
        slot_tag_d  = fl_entry.tag;
        slot_att_d  = fl_att;
        slot_sent_d = in_q.now_ms;
        if (!in_q.send_ok) begin
          busy_d     = 1'b0;
          flush_at_d = in_q.now_ms + {16'b0, cfg_i.retry_interval_ms};
          evs[ev_n] = mk_ev(rosi_pkg::EvSendFail, fl_entry.tag, fl_att, '0, count_d, '0);
          ev_n = ev_n + 1'b1;
        end else begin
          busy_d     = 1'b1;
          head_d     = ring_next(head_d);
          count_d    = count_d - 1'b1;
          flush_at_d = in_q.now_ms;
          evs[ev_n] = mk_ev(rosi_pkg::EvSent, fl_entry.tag, fl_att, '0, count_d, '0);
          ev_n = ev_n + 1'b1;
          if (in_q.sync_status != '0) begin
            busy_d = 1'b0;
            evs[ev_n] = mk_ev(rosi_pkg::EvAnswered, fl_entry.tag, fl_att, '0, count_d,
                              in_q.sync_status);
            ev_n = ev_n + 1'b1;
          end
        end
      end
    end
  end

  // Mark the final result and hand the list over
  always_comb begin
    batch_o.load = fire;
    batch_o.n    = ev_n;
    batch_o.ev   = evs;
    for (int i = 0; i < MaxEv; i++) begin
      batch_o.ev[i].last_event = (ev_n == EvCntW'(i + 1));
    end
  end

  // Sender state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      slot_tag_q  <= '0;
      slot_att_q  <= '0;
      slot_sent_q <= '0;
      flush_at_q  <= '0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      slot_tag_q  <= slot_tag_d;
      slot_att_q  <= slot_att_d;
      slot_sent_q <= slot_sent_d;
      flush_at_q  <= flush_at_d;
    end
  end

  // Outbox RAM: at most one write per transaction, prefetch head and the entry after it
  assign ram_we_o        = wr_en;
  assign ram_waddr_o     = wr_pos;
  assign ram_wdata_o.tag = enq_tag;
  assign ram_wdata_o.att = enq_att;
  assign ram_raddr_a_o   = head_d;
  assign ram_raddr_b_o   = ring_next(head_d);

endmodule

>>> hw/rtl/rosi_evbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosi_evbuf: result buffer
// Holds the results of one transaction and shifts them out one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module rosi_evbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rosi_pkg::ev_batch_t  batch_i,
  output logic                 buf_free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rosi_pkg::out_item_t  out_item_o
);

  localparam int unsigned MaxEv  = rosi_pkg::MaxEvents;
  localparam int unsigned EvCntW = rosi_pkg::EvCntW;

  rosi_pkg::out_item_t [MaxEv-1:0] ev_q;
  logic [EvCntW-1:0]               n_q;
  logic                            out_acc;

  assign out_valid_o = (n_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign buf_free_o  = (n_q == '0) || ((n_q == EvCntW'(1)) && out_acc);
  assign out_item_o  = ev_q[0];

  // Count of results left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (batch_i.load) begin
      n_q <= batch_i.n;
    end else if (out_acc) begin
      n_q <= n_q - 1'b1;
    end
  end

  // Load a new list or advance by one
  always_ff @(posedge clk_i) begin
    if (batch_i.load) begin
      ev_q <= batch_i.ev;
    end else if (out_acc) begin
      for (int i = 0; i < MaxEv - 1; i++) begin
        ev_q[i] <= ev_q[i + 1];
      end
    end
  end

endmodule

>>> hw/rtl/retry_outbox_single_inflight_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retry_outbox_single_inflight_core: stop-and-wait sender with retry outbox
// Sends reads one at a time, queues them in a drop-oldest ring when the link
// or the in-flight slot is not free or a send fails, expires and retries unanswered reads.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_item_i  (rosi_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (rosi_pkg::out_item_t)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A transaction waits in the input register and is processed once the
// result buffer is empty or hands out its last result. Results leave one
// per cycle unless the output stalls, so the next transaction waits until
// every result of the one before has been handed out.
// The outbox RAM keeps the head entry and the one after it read ahead.
// Reset clears the sender state and loads the register defaults; outbox
// contents need no clearing. A stalled output holds the buffer and the
// input register, which then stalls the input.
// ----------------------------------------------------------------------------
module retry_outbox_single_inflight_core #(
  parameter int unsigned OUTBOX_DEPTH = rosi_pkg::OutboxDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rosi_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rosi_pkg::out_item_t            out_item_o,
  input  logic                           cfg_we_i,
  input  logic [rosi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rosi_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (OUTBOX_DEPTH > 1) ? $clog2(OUTBOX_DEPTH) : 1;

  rosi_pkg::cfg_t      cfg;
  rosi_pkg::ev_batch_t batch;
  logic                buf_free;
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  rosi_pkg::entry_t    ram_wdata;
  logic [IdxW-1:0]     ram_raddr_a;
  logic [IdxW-1:0]     ram_raddr_b;
  rosi_pkg::entry_t    ram_rdata_a;
  rosi_pkg::entry_t    ram_rdata_b;

  rosi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rosi_ram #(
    .Width ($bits(rosi_pkg::entry_t)),
    .Depth (OUTBOX_DEPTH)
  ) u_outbox (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  rosi_engine #(
    .OUTBOX_DEPTH (OUTBOX_DEPTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_item_i     (in_item_i),
    .buf_free_i    (buf_free),
    .batch_o       (batch),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_rdata_b_i (ram_rdata_b)
  );

  rosi_evbuf u_evbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .buf_free_o  (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> hw/rtl/rosi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosi_checker: port-level checks of the retry outbox core
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module rosi_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rosi_pkg::out_item_t out_item_o
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Only answered events carry latency and status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.event_kind != rosi_pkg::EvAnswered) |->
      (out_item_o.latency_ms == '0) && (out_item_o.answer_status == '0))
    else $error("latency or status on a non-answered event");

  // A lost read and a dropped oldest entry are always followed by another event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.event_kind == rosi_pkg::EvLost) ||
                    (out_item_o.event_kind == rosi_pkg::EvDropOldest)) |->
      !out_item_o.last_event)
    else $error("lost or dropped event closed a transaction");

  // A sent read has made at least one attempt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.event_kind == rosi_pkg::EvSent) |->
      (out_item_o.attempt_count != '0))
    else $error("sent event with zero attempts");

  // A queued read leaves the outbox non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.event_kind == rosi_pkg::EvQueued) |->
      (out_item_o.pending_count != '0))
    else $error("queued event with empty outbox");

endmodule

bind retry_outbox_single_inflight_core rosi_checker u_rosi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
